@@ sv/resource_toc_encoder_defines.svh @@
// assertion macros for the resource table-of-contents encoder checks
`ifndef RESOURCE_TOC_ENCODER_DEFINES_SVH
`define RESOURCE_TOC_ENCODER_DEFINES_SVH

// both macros sample on clk and are disabled while rst_n is low
`define RTOC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("toc encoder check failed");

`define RTOC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("toc encoder check failed");

`endif

@@ sv/rtoc_pkg.sv @@
// shared types, constants and microcode table for the toc encoder
`timescale 1ns / 1ps

package rtoc_pkg;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_IDLE  = 4'd0;
    localparam step_t STEP_CHECK = 4'd1;
    localparam step_t STEP_VALID = 4'd2;
    localparam step_t STEP_TYPE  = 4'd3;
    localparam step_t STEP_QUAL  = 4'd4;
    localparam step_t STEP_QHI   = 4'd5;
    localparam step_t STEP_QLO   = 4'd6;
    localparam step_t STEP_BLANK = 4'd7;
    localparam step_t STEP_LEN   = 4'd8;
    localparam step_t STEP_LMID  = 4'd9;
    localparam step_t STEP_LLO   = 4'd10;

    localparam logic [7:0]  TYPE_GAP_MAX = 8'h3f;
    localparam logic [7:0]  QUAL_MARK    = 8'h40;
    localparam logic [7:0]  BLANK_BYTE   = 8'h80;
    localparam logic [7:0]  LEN_LONG_HI  = 8'hc0;
    localparam logic [23:0] LEN_LIMIT    = 24'h100000;
    localparam logic [23:0] LEN_SHORT    = 24'h000040;

    typedef enum logic [1:0] {
        STAT_OK     = 2'd0,
        STAT_ORDER  = 2'd1,
        STAT_LENGTH = 2'd2,
        STAT_STICKY = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0]  type_id;
        logic [15:0] qualifier;
        logic [15:0] resource_id;
        logic [23:0] payload_length;
        logic        first_record;
    } rec_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [15:0] repeat_count;
        logic        last_of_run;
        status_t     status;
        logic [31:0] heap_total;
    } toc_t;

    typedef enum logic [2:0] {
        COND_ALWAYS,
        COND_IN,
        COND_SKIP,
        COND_BAD,
        COND_TYPE_GT,
        COND_QUAL_GT,
        COND_RID_GT,
        COND_LEN_SMALL
    } cond_t;

    typedef enum logic [3:0] {
        SEL_ERR,
        SEL_TGAP,
        SEL_QMARK,
        SEL_QHI,
        SEL_QLO,
        SEL_BLANK,
        SEL_LSHORT,
        SEL_LHI,
        SEL_LMID,
        SEL_LLO
    } sel_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_ERR,
        ACT_HEAP,
        ACT_TYPE,
        ACT_QUAL,
        ACT_RID
    } act_t;

    typedef struct packed {
        logic  emit;
        sel_t  sel;
        logic  last;
        act_t  act;
        step_t next;
    } branch_t;

    typedef struct packed {
        cond_t   cond;
        branch_t on_true;
        branch_t on_false;
    } ucode_t;

    typedef struct packed {
        logic emit;
        sel_t sel;
        logic last;
        act_t act;
    } dp_ctrl_t;

    typedef struct packed {
        logic skip;
        logic bad;
        logic type_gt;
        logic qual_gt;
        logic rid_gt;
        logic len_small;
        logic out_free;
    } dp_flags_t;

    function automatic branch_t mk_br(logic emit, sel_t sel, logic last, act_t act,
                                      step_t next);
        branch_t b;
        b.emit = emit;
        b.sel  = sel;
        b.last = last;
        b.act  = act;
        b.next = next;
        return b;
    endfunction

    function automatic ucode_t mk_uc(cond_t cond, branch_t t, branch_t f);
        ucode_t u;
        u.cond     = cond;
        u.on_true  = t;
        u.on_false = f;
        return u;
    endfunction

    function automatic ucode_t ucode_rom(step_t step);
        ucode_t u;
        case (step)
            STEP_IDLE:  u = mk_uc(COND_IN,
                              mk_br(1'b0, SEL_ERR, 1'b0, ACT_LOAD, STEP_CHECK),
                              mk_br(1'b0, SEL_ERR, 1'b0, ACT_NONE, STEP_IDLE));
            STEP_CHECK: u = mk_uc(COND_SKIP,
                              mk_br(1'b0, SEL_ERR, 1'b0, ACT_NONE, STEP_IDLE),
                              mk_br(1'b0, SEL_ERR, 1'b0, ACT_NONE, STEP_VALID));
            STEP_VALID: u = mk_uc(COND_BAD,
                              mk_br(1'b1, SEL_ERR, 1'b1, ACT_ERR, STEP_IDLE),
                              mk_br(1'b0, SEL_ERR, 1'b0, ACT_HEAP, STEP_TYPE));
            STEP_TYPE:  u = mk_uc(COND_TYPE_GT,
                              mk_br(1'b1, SEL_TGAP, 1'b0, ACT_TYPE, STEP_TYPE),
                              mk_br(1'b0, SEL_TGAP, 1'b0, ACT_NONE, STEP_QUAL));
            STEP_QUAL:  u = mk_uc(COND_QUAL_GT,
                              mk_br(1'b1, SEL_QMARK, 1'b0, ACT_NONE, STEP_QHI),
                              mk_br(1'b0, SEL_QMARK, 1'b0, ACT_NONE, STEP_BLANK));
            STEP_QHI:   u = mk_uc(COND_ALWAYS,
                              mk_br(1'b1, SEL_QHI, 1'b0, ACT_NONE, STEP_QLO),
                              mk_br(1'b1, SEL_QHI, 1'b0, ACT_NONE, STEP_QLO));
            STEP_QLO:   u = mk_uc(COND_ALWAYS,
                              mk_br(1'b1, SEL_QLO, 1'b0, ACT_QUAL, STEP_BLANK),
                              mk_br(1'b1, SEL_QLO, 1'b0, ACT_QUAL, STEP_BLANK));
            STEP_BLANK: u = mk_uc(COND_RID_GT,
                              mk_br(1'b1, SEL_BLANK, 1'b0, ACT_NONE, STEP_LEN),
                              mk_br(1'b0, SEL_BLANK, 1'b0, ACT_NONE, STEP_LEN));
            STEP_LEN:   u = mk_uc(COND_LEN_SMALL,
                              mk_br(1'b1, SEL_LSHORT, 1'b1, ACT_RID, STEP_IDLE),
                              mk_br(1'b1, SEL_LHI, 1'b0, ACT_NONE, STEP_LMID));
            STEP_LMID:  u = mk_uc(COND_ALWAYS,
                              mk_br(1'b1, SEL_LMID, 1'b0, ACT_NONE, STEP_LLO),
                              mk_br(1'b1, SEL_LMID, 1'b0, ACT_NONE, STEP_LLO));
            STEP_LLO:   u = mk_uc(COND_ALWAYS,
                              mk_br(1'b1, SEL_LLO, 1'b1, ACT_RID, STEP_IDLE),
                              mk_br(1'b1, SEL_LLO, 1'b1, ACT_RID, STEP_IDLE));
            default:    u = mk_uc(COND_ALWAYS,
                              mk_br(1'b0, SEL_ERR, 1'b0, ACT_NONE, STEP_IDLE),
                              mk_br(1'b0, SEL_ERR, 1'b0, ACT_NONE, STEP_IDLE));
        endcase
        return u;
    endfunction

endpackage

@@ sv/rtoc_if.sv @@
// record and toc byte channel interfaces
`timescale 1ns / 1ps

interface rtoc_rec_if import rtoc_pkg::*; ();
    logic valid;
    logic ready;
    rec_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rtoc_toc_if import rtoc_pkg::*; ();
    logic valid;
    logic ready;
    toc_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ sv/rtoc_seq.sv @@
// microcode sequencer: step counter, control rom and branch selection
`timescale 1ns / 1ps

module rtoc_seq import rtoc_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      rec_valid,
    output logic      rec_ready,
    input  dp_flags_t flags,
    output dp_ctrl_t  ctrl
);

    step_t   step_reg;
    step_t   step_next;
    ucode_t  uc;
    branch_t br;
    logic    cond_hit;
    logic    stall;

    always_comb
    begin
        uc = ucode_rom(step_reg);
        case (uc.cond)
            COND_ALWAYS:    cond_hit = 1'b1;
            COND_IN:        cond_hit = rec_valid;
            COND_SKIP:      cond_hit = flags.skip;
            COND_BAD:       cond_hit = flags.bad;
            COND_TYPE_GT:   cond_hit = flags.type_gt;
            COND_QUAL_GT:   cond_hit = flags.qual_gt;
            COND_RID_GT:    cond_hit = flags.rid_gt;
            COND_LEN_SMALL: cond_hit = flags.len_small;
            default:        cond_hit = 1'b0;
        endcase
        br    = cond_hit ? uc.on_true : uc.on_false;
        // hold the step while the output register cannot take the beat
        stall = br.emit && !flags.out_free;

        ctrl.emit = br.emit && !stall;
        ctrl.sel  = br.sel;
        ctrl.last = br.last;
        ctrl.act  = stall ? ACT_NONE : br.act;
        step_next = stall ? step_reg : br.next;
    end

    assign rec_ready = (step_reg == STEP_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

@@ sv/rtoc_dp.sv @@
// datapath: record latch, cursor and heap state, byte selection, output register
`timescale 1ns / 1ps

module rtoc_dp import rtoc_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  rec_t      rec_data,
    input  dp_ctrl_t  ctrl,
    output dp_flags_t flags,
    output logic      toc_valid,
    input  logic      toc_ready,
    output toc_t      toc_data
);

    rec_t        rec_reg;
    rec_t        rec_next;
    logic [7:0]  ct_reg;
    logic [7:0]  ct_next;
    logic [15:0] cq_reg;
    logic [15:0] cq_next;
    logic [16:0] cr_reg;
    logic [16:0] cr_next;
    logic [31:0] heap_reg;
    logic [31:0] heap_next;
    logic        err_reg;
    logic        err_next;
    logic        toc_valid_reg;
    logic        toc_valid_next;
    toc_t        toc_reg;
    toc_t        toc_next;

    status_t     err_code;
    logic        backward;
    logic [7:0]  tgap_full;
    logic [7:0]  tgap;
    logic [15:0] qgap;
    logic [16:0] blank_full;
    logic [16:0] rid_ext;
    logic [7:0]  sel_byte;
    logic [15:0] sel_rep;

    assign rid_ext    = {1'b0, rec_reg.resource_id};
    assign backward   = {rec_reg.type_id, rec_reg.qualifier, rid_ext}
                        < {ct_reg, cq_reg, cr_reg};
    assign tgap_full  = rec_reg.type_id - ct_reg - 8'd1;
    assign tgap       = (tgap_full > TYPE_GAP_MAX) ? TYPE_GAP_MAX : tgap_full;
    assign qgap       = rec_reg.qualifier - cq_reg - 16'd1;
    assign blank_full = rid_ext - cr_reg;

    always_comb
    begin
        if (err_reg)
            err_code = STAT_STICKY;
        else if (backward)
            err_code = STAT_ORDER;
        else if (rec_reg.payload_length >= LEN_LIMIT)
            err_code = STAT_LENGTH;
        else
            err_code = STAT_OK;
    end

    always_comb
    begin
        flags.skip      = (rec_reg.type_id == 8'd0) || (rec_reg.resource_id == 16'd0);
        flags.bad       = (err_code != STAT_OK);
        flags.type_gt   = rec_reg.type_id > ct_reg;
        flags.qual_gt   = rec_reg.qualifier > cq_reg;
        flags.rid_gt    = rid_ext > cr_reg;
        flags.len_small = rec_reg.payload_length < LEN_SHORT;
        flags.out_free  = !toc_valid_reg || toc_ready;
    end

    always_comb
    begin
        sel_rep = 16'd1;
        case (ctrl.sel)
            SEL_ERR:
            begin
                sel_byte = 8'd0;
                sel_rep  = 16'd0;
            end
            SEL_TGAP:   sel_byte = tgap;
            SEL_QMARK:  sel_byte = QUAL_MARK;
            SEL_QHI:    sel_byte = qgap[15:8];
            SEL_QLO:    sel_byte = qgap[7:0];
            SEL_BLANK:
            begin
                sel_byte = BLANK_BYTE;
                sel_rep  = blank_full[15:0];
            end
            SEL_LSHORT: sel_byte = BLANK_BYTE | {2'b00, rec_reg.payload_length[5:0]};
            SEL_LHI:    sel_byte = LEN_LONG_HI | rec_reg.payload_length[23:16];
            SEL_LMID:   sel_byte = rec_reg.payload_length[15:8];
            SEL_LLO:    sel_byte = rec_reg.payload_length[7:0];
            default:    sel_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        rec_next  = rec_reg;
        ct_next   = ct_reg;
        cq_next   = cq_reg;
        cr_next   = cr_reg;
        heap_next = heap_reg;
        err_next  = err_reg;
        case (ctrl.act)
            ACT_NONE: ;
            ACT_LOAD:
            begin
                rec_next = rec_data;
                if (rec_data.first_record)
                begin
                    ct_next   = 8'd1;
                    cq_next   = 16'd0;
                    cr_next   = 17'd1;
                    heap_next = 32'd0;
                    err_next  = 1'b0;
                end
            end
            ACT_ERR:  err_next = 1'b1;
            ACT_HEAP: heap_next = heap_reg + {8'd0, rec_reg.payload_length};
            ACT_TYPE:
            begin
                ct_next = ct_reg + tgap + 8'd1;
                cq_next = 16'd0;
                cr_next = 17'd1;
            end
            ACT_QUAL:
            begin
                cq_next = rec_reg.qualifier;
                cr_next = 17'd1;
            end
            ACT_RID:  cr_next = rid_ext + 17'd1;
            default: ;
        endcase
    end

    always_comb
    begin
        toc_next       = toc_reg;
        toc_valid_next = toc_valid_reg;
        if (ctrl.emit)
        begin
            toc_valid_next        = 1'b1;
            toc_next.out_byte     = sel_byte;
            toc_next.repeat_count = sel_rep;
            toc_next.last_of_run  = ctrl.last;
            toc_next.status       = (ctrl.sel == SEL_ERR) ? err_code : STAT_OK;
            toc_next.heap_total   = heap_reg;
        end
        else if (toc_ready)
        begin
            toc_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ct_reg        <= 8'd1;
            cq_reg        <= 16'd0;
            cr_reg        <= 17'd1;
            heap_reg      <= 32'd0;
            err_reg       <= 1'b0;
            toc_valid_reg <= 1'b0;
        end
        else
        begin
            ct_reg        <= ct_next;
            cq_reg        <= cq_next;
            cr_reg        <= cr_next;
            heap_reg      <= heap_next;
            err_reg       <= err_next;
            toc_valid_reg <= toc_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
        toc_reg <= toc_next;
    end

    assign toc_valid = toc_valid_reg;
    assign toc_data  = toc_reg;

endmodule

@@ sv/resource_toc_encoder.sv @@
// resource table-of-contents encoder, top level
// channels: rec takes one sorted resource record per beat (type, qualifier, id,
//   length, restart flag); toc gives toc bytes, each with a repeat count, a
//   last-of-record mark, a status and the running heap total
// a record is taken only while the sequencer sits in its idle step; it then
//   runs one microcode step per cycle while the toc output can take its beats:
//   check, validate, one step per type advance plus one, qualifier (one or
//   three), blank run, length (one or three); a skipped record ends after
//   check, an error record after validate
// a record emits at most 4 type-advance bytes
// the first toc beat of a record is the error beat on an error, else the first
//   of its type-advance, qualifier, blank-run and length bytes that is emitted
// the toc output is one register; a stalled receiver holds the step counter on
//   the beat that cannot be placed, so nothing is lost or repeated
// reset: cursor type 1, qualifier 0, resource 1, heap total 0, no error, no
//   beat pending; a record with the restart flag does the same, but for the
//   pending beat, before it is handled
`timescale 1ns / 1ps

module resource_toc_encoder import rtoc_pkg::*; (
    input logic         clk,
    input logic         rst_n,
    rtoc_rec_if.sink    rec,
    rtoc_toc_if.source  toc
);

    dp_ctrl_t  ctrl;
    dp_flags_t flags;

    rtoc_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (rec.valid),
        .rec_ready (rec.ready),
        .flags     (flags),
        .ctrl      (ctrl)
    );

    rtoc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_data  (rec.data),
        .ctrl      (ctrl),
        .flags     (flags),
        .toc_valid (toc.valid),
        .toc_ready (toc.ready),
        .toc_data  (toc.data)
    );

endmodule

@@ sv/rtoc_checker.sv @@
// port-level checks for the toc encoder, bound to the top level
`timescale 1ns / 1ps
`include "resource_toc_encoder_defines.svh"

module rtoc_checker import rtoc_pkg::*; (
    input logic clk,
    input logic rst_n,
    input logic rec_valid,
    input logic rec_ready,
    input logic toc_valid,
    input logic toc_ready,
    input toc_t toc_data
);

    // error beats carry no byte run and close the record
    `RTOC_ASSERT_SAME(a_err_beat, toc_valid && (toc_data.status != STAT_OK),
        (toc_data.repeat_count == 16'd0) && toc_data.last_of_run)

    // encoded beats always emit at least once
    `RTOC_ASSERT_SAME(a_ok_rep, toc_valid && (toc_data.status == STAT_OK),
        toc_data.repeat_count != 16'd0)

    // a taken record keeps the sequencer busy for the next cycle
    `RTOC_ASSERT_NEXT(a_rec_busy, rec_valid && rec_ready, !rec_ready)

    // a stalled beat holds
    `RTOC_ASSERT_NEXT(a_toc_hold, toc_valid && !toc_ready, toc_valid && $stable(toc_data))

endmodule

bind resource_toc_encoder rtoc_checker u_rtoc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_valid (rec.valid),
    .rec_ready (rec.ready),
    .toc_valid (toc.valid),
    .toc_ready (toc.ready),
    .toc_data  (toc.data)
);
